// ----- rtl/kstdl_pkg.sv -----
// Shared types and constants for the keyed slot table draw-list unit.
package kstdl_pkg;

    localparam int SLOTS       = 64;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int MAX_RESULTS = 64;
    localparam int K_W         = $clog2(MAX_RESULTS + 1);
    localparam int ID_W        = 32;
    localparam int CFG_W       = 10;

    // Per-quad geometry and emit headroom
    localparam int VTX_PER_SLOT = 4;
    localparam int IDX_PER_SLOT = 6;
    localparam int VTX_ROOM     = 6;
    localparam int IDX_ROOM     = 12;

    localparam logic [CFG_W-1:0] MAX_VTX_RST = CFG_W'(256);
    localparam logic [CFG_W-1:0] MAX_IDX_RST = CFG_W'(384);

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_UNHL   = 3'd3,
        OP_EMIT   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_MAX_VTX = 2'd0,
        CFG_MAX_IDX = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        t_status     status;
        logic [5:0]  slot;
        logic [7:0]  base_vertex;
        logic [8:0]  base_index;
        logic        is_highlighted;
        logic        last;
        logic [8:0]  split_index;
        logic [8:0]  split_vertex;
        logic [8:0]  total_indices;
        logic [8:0]  total_vertices;
    } t_res;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic add_commit;
        logic put_ok;
        logic clear_all;
        logic clear_hl;
        logic emit_start;
        logic emit_step;
        logic emit_flush;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic n_zero;
        logic scan_done;
        logic emit_done;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/kstdl_ctrl.sv -----
// Sequencer for the slot table: decodes the latched item and steps the datapath.
module kstdl_ctrl
    import kstdl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_COMMIT,
        S_RESP,
        S_EMIT,
        S_FLUSH
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op)
                    OP_ADD: begin
                        // scan start also clears the match/free flags of the last scan
                        o_cmd.scan_start = 1'b1;
                        if (i_stat.n_zero) begin
                            n_state = S_COMMIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_REMOVE: begin
                        if (i_stat.n_zero) begin
                            n_state = S_RESP;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                        n_state         = S_RESP;
                    end
                    OP_UNHL: begin
                        o_cmd.clear_hl = 1'b1;
                        n_state        = S_RESP;
                    end
                    OP_EMIT: begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = S_EMIT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = (i_stat.op == OP_ADD) ? S_COMMIT : S_RESP;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.add_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.put_ok = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_stat.emit_done) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.emit_step = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_flush = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// ----- rtl/kstdl_dpath.sv -----
// Slot table storage, scan compare, emit walk counters and result register.
module kstdl_dpath
    import kstdl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [2:0]       i_opcode,
    input  logic             i_key_kind,
    input  logic [ID_W-1:0]  i_key_id,
    input  logic             i_mark_highlight,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_res             o_res,
    output logic             o_res_valid,
    input  logic             i_res_ready
);

    // Latched item
    t_op              r_op;
    logic             r_kind;
    logic [ID_W-1:0]  r_id;
    logic             r_mark;

    logic [CFG_W-1:0] r_max_vtx;
    logic [CFG_W-1:0] r_max_idx;

    // Table state; ids live in memory as {kind, id}, the other kind reads as zero
    logic [CNT_W-1:0] r_count;
    logic [SLOTS-1:0] r_valid;
    logic [SLOTS-1:0] r_hl;
    logic [ID_W:0]    r_mem [SLOTS];

    // Scan pipeline: issue address, then compare on registered read data
    logic [CNT_W-1:0]  r_idx;
    logic [ID_W:0]     r_rd;
    logic              r_pipe_vld;
    logic [SLOT_W-1:0] r_cmp_idx;
    logic              r_match_f;
    logic [SLOT_W-1:0] r_match_idx;
    logic              r_free_f;
    logic [SLOT_W-1:0] r_free_idx;

    // Emit walk
    logic              r_pass;
    logic              r_done;
    logic [K_W-1:0]    r_k;
    logic [8:0]        r_nv;
    logic [8:0]        r_ni;
    logic [8:0]        r_sv;
    logic [8:0]        r_si;
    logic              r_pend_vld;
    t_res              r_pend;

    t_res r_out;
    logic r_out_vld;

    logic              w_out_free;
    logic              w_issue;
    logic [ID_W-1:0]   w_key;
    logic              w_hit;
    logic              w_cmp_valid;
    logic [SLOT_W-1:0] w_eidx;
    logic              w_at_end;
    logic              w_elig;
    logic              w_room_fail;
    logic              w_kfull;
    logic              w_pass_end;
    logic              w_emit;
    logic              w_stall;
    logic              w_add_full;
    logic              w_add_app;
    logic [SLOT_W-1:0] w_add_slot;
    t_res              w_new;
    logic              w_load_out;
    t_res              w_out_next;

    assign w_out_free  = !r_out_vld || i_res_ready;
    assign w_issue     = i_cmd.scan_step && (r_idx != r_count);

    assign w_cmp_valid = r_valid[r_cmp_idx];
    assign w_key       = (w_cmp_valid && (r_rd[ID_W] == r_kind)) ? r_rd[ID_W-1:0] : '0;
    assign w_hit       = (w_key == r_id);

    // Emit decisions for the slot under the walk index
    assign w_eidx      = r_idx[SLOT_W-1:0];
    assign w_at_end    = (r_idx == r_count);
    assign w_elig      = !w_at_end && r_valid[w_eidx] && (r_hl[w_eidx] == r_pass);
    assign w_room_fail = (({2'b00, r_nv} + 11'(VTX_ROOM)) >= {1'b0, r_max_vtx}) ||
                         (({2'b00, r_ni} + 11'(IDX_ROOM)) >= {1'b0, r_max_idx});
    assign w_kfull     = (r_k >= K_W'(MAX_RESULTS));
    assign w_pass_end  = w_at_end || (w_elig && (w_room_fail || w_kfull));
    assign w_stall     = r_pend_vld && !w_out_free;
    assign w_emit      = i_cmd.emit_step && !r_done && !w_pass_end && w_elig && !w_stall;

    // Add placement: matching slot, else first free, else append, else full
    always_comb begin
        w_add_full = 1'b0;
        w_add_app  = 1'b0;
        w_add_slot = r_count[SLOT_W-1:0];
        if (r_match_f) begin
            w_add_slot = r_match_idx;
        end else if (r_free_f) begin
            w_add_slot = r_free_idx;
        end else if (r_count >= CNT_W'(SLOTS)) begin
            w_add_full = 1'b1;
            w_add_slot = '0;
        end else begin
            w_add_app  = 1'b1;
        end
    end

    always_comb begin
        w_new                = '0;
        w_new.status         = ST_OK;
        w_new.slot           = 6'(w_eidx);
        w_new.base_vertex    = r_nv[7:0];
        w_new.base_index     = r_ni;
        w_new.is_highlighted = r_pass;
    end

    always_comb begin
        w_load_out = 1'b0;
        w_out_next = '0;
        w_out_next.status = ST_OK;
        w_out_next.last   = 1'b1;
        if (i_cmd.add_commit) begin
            w_load_out = 1'b1;
            w_out_next.status = w_add_full ? ST_FULL : ST_OK;
            w_out_next.slot   = 6'(w_add_slot);
        end else if (i_cmd.put_ok) begin
            w_load_out = 1'b1;
        end else if (i_cmd.emit_flush) begin
            w_load_out = 1'b1;
            if (r_pend_vld) begin
                w_out_next                = r_pend;
                w_out_next.last           = 1'b1;
                w_out_next.split_index    = r_si;
                w_out_next.split_vertex   = r_sv;
                w_out_next.total_indices  = r_ni;
                w_out_next.total_vertices = r_nv;
            end else begin
                w_out_next.status = ST_EMPTY;
            end
        end else if (w_emit && r_pend_vld) begin
            w_load_out = 1'b1;
            w_out_next = r_pend;
        end
    end

    // Id memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_commit && !w_add_full) begin
            r_mem[w_add_slot] <= {r_kind, r_id};
        end
        if (w_issue) begin
            r_rd <= r_mem[r_idx[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vtx  <= MAX_VTX_RST;
            r_max_idx  <= MAX_IDX_RST;
            r_count    <= '0;
            r_valid    <= '0;
            r_hl       <= '0;
            r_pipe_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_done     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_VTX: r_max_vtx <= i_cfg_data;
                    CFG_MAX_IDX: r_max_idx <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.load) begin
                r_op   <= t_op'(i_opcode);
                r_kind <= i_key_kind;
                r_id   <= i_key_id;
                r_mark <= i_mark_highlight;
            end

            // Scan
            if (i_cmd.scan_start) begin
                r_idx      <= '0;
                r_pipe_vld <= 1'b0;
                r_match_f  <= 1'b0;
                r_free_f   <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pipe_vld <= w_issue;
                if (w_issue) begin
                    r_cmp_idx <= r_idx[SLOT_W-1:0];
                    r_idx     <= r_idx + 1'b1;
                end
            end
            if (r_pipe_vld) begin
                if (r_op == OP_REMOVE) begin
                    if (w_hit) r_valid[r_cmp_idx] <= 1'b0;
                end else begin
                    if (w_cmp_valid && w_hit && !r_match_f) begin
                        r_match_f   <= 1'b1;
                        r_match_idx <= r_cmp_idx;
                    end
                    if (!w_cmp_valid && !r_free_f) begin
                        r_free_f   <= 1'b1;
                        r_free_idx <= r_cmp_idx;
                    end
                end
            end

            if (i_cmd.add_commit && !w_add_full) begin
                r_valid[w_add_slot] <= 1'b1;
                r_hl[w_add_slot]    <= r_mark;
                if (w_add_app) r_count <= r_count + 1'b1;
            end

            if (i_cmd.clear_all) r_count <= '0;

            if (i_cmd.clear_hl) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (CNT_W'(i) < r_count) r_hl[i] <= 1'b0;
                end
            end

            // Emit walk
            if (i_cmd.emit_start) begin
                r_idx      <= '0;
                r_pass     <= 1'b0;
                r_done     <= 1'b0;
                r_k        <= '0;
                r_nv       <= '0;
                r_ni       <= '0;
                r_sv       <= '0;
                r_si       <= '0;
                r_pend_vld <= 1'b0;
            end else if (i_cmd.emit_step && !r_done) begin
                if (w_pass_end) begin
                    if (!r_pass) begin
                        r_pass <= 1'b1;
                        r_sv   <= r_nv;
                        r_si   <= r_ni;
                        r_idx  <= '0;
                    end else begin
                        r_done <= 1'b1;
                    end
                end else if (w_emit) begin
                    r_pend     <= w_new;
                    r_pend_vld <= 1'b1;
                    r_k        <= r_k + 1'b1;
                    r_nv       <= r_nv + 9'(VTX_PER_SLOT);
                    r_ni       <= r_ni + 9'(IDX_PER_SLOT);
                    r_idx      <= r_idx + 1'b1;
                end else if (!w_elig) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.emit_flush) r_pend_vld <= 1'b0;

            // Result register
            if (w_load_out) begin
                r_out     <= w_out_next;
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.n_zero    = (r_count == '0);
    assign o_stat.scan_done = (r_idx == r_count) && !r_pipe_vld;
    assign o_stat.emit_done = r_done;
    assign o_stat.out_free  = w_out_free;

    assign o_res       = r_out;
    assign o_res_valid = r_out_vld;

endmodule

// ----- rtl/keyed_slot_table_draw_list_unit.sv -----
// Top level of the keyed slot table with two-pass draw-list emitter.
//
// A 64-slot table keyed by object id or drawable id, driven one transaction
// at a time on the input stream. Add, remove, clear, unhighlight and emit
// each give their results on the output stream; the input is taken again
// once the last result of a transaction is in the output register. Add and
// remove read the id memory one slot a cycle across the live entries. Emit
// walks the valid/highlight flags twice, one slot a cycle while the output
// register can take results, giving up to one result per cycle and stalling
// under output back-pressure. The last emit result carries the split and
// total counts; an emit with nothing to draw returns a single empty status.
// Configuration writes are accepted at any time but are meant for idle.
module keyed_slot_table_draw_list_unit
    import kstdl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] opcode, [34:3] key_id, [35] mark_highlight, [39:36] zero
    input  logic [39:0] i_s_tdata,
    // [0] key_kind
    input  logic [0:0]  i_s_tuser,
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] status, [7:2] slot, [15:8] base_vertex, [24:16] base_index,
    // [25] is_highlighted, [34:26] split_index, [43:35] split_vertex,
    // [52:44] total_indices, [61:53] total_vertices, [63:62] zero
    output logic [63:0] o_m_tdata,
    output logic        o_m_tlast,
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    t_cmd w_cmd;
    t_stat w_stat;
    t_res w_res;
    logic w_accept;

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    kstdl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (o_s_tready)
    );

    kstdl_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_opcode         (i_s_tdata[2:0]),
        .i_key_kind       (i_s_tuser[0]),
        .i_key_id         (i_s_tdata[34:3]),
        .i_mark_highlight (i_s_tdata[35]),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_res            (w_res),
        .o_res_valid      (o_m_tvalid),
        .i_res_ready      (i_m_tready)
    );

    // Pack the result transaction, first field lowest
    assign o_m_tdata = {2'b00,
                        w_res.total_vertices,
                        w_res.total_indices,
                        w_res.split_vertex,
                        w_res.split_index,
                        w_res.is_highlighted,
                        w_res.base_index,
                        w_res.base_vertex,
                        w_res.slot,
                        w_res.status};
    assign o_m_tlast = w_res.last;

endmodule

// ----- tb/sv/keyed_slot_table_draw_list_checker.sv -----
// Checker for the keyed slot table draw-list unit: tracks the table and compares every result.
`timescale 1ns / 100ps
module keyed_slot_table_draw_list_checker
    import kstdl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output int          o_bad_results,
    output int          o_results_due
);

    localparam int REPORT_MAX = 10;

    // Shadow of the table and its registers
    logic             slot_used [SLOTS];
    logic [ID_W-1:0]  slot_obj  [SLOTS];
    logic [ID_W-1:0]  slot_drw  [SLOTS];
    logic             slot_hl   [SLOTS];
    int               live_count;
    logic [CFG_W-1:0] vtx_cap;
    logic [CFG_W-1:0] idx_cap;

    t_res table_results [$];
    t_res got;
    t_res want;
    int   bad_count;

    function automatic logic [ID_W-1:0] slot_key(int i, logic kind);
        return kind ? slot_drw[i] : slot_obj[i];
    endfunction

    function automatic t_res single_result(t_status st, int slot_no);
        t_res r;
        r        = '0;
        r.status = st;
        r.slot   = 6'(slot_no);
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic string res_text(t_res r);
        return $sformatf("st=%0d slot=%0d bv=%0d bi=%0d hl=%0b last=%0b si=%0d sv=%0d ti=%0d tv=%0d",
                         r.status, r.slot, r.base_vertex, r.base_index, r.is_highlighted,
                         r.last, r.split_index, r.split_vertex, r.total_indices,
                         r.total_vertices);
    endfunction

    // Applies one command to the shadow table and queues the results it gives
    task automatic run_table_op(input logic [2:0] op, input logic kind,
                                input logic [ID_W-1:0] key, input logic hl);
        int   n;
        int   hit;
        int   nv;
        int   ni;
        int   sv;
        int   si;
        int   k;
        bit   have_held;
        t_res held;
        n = (live_count > SLOTS) ? SLOTS : live_count;
        case (op)
            OP_ADD: begin
                hit = -1;
                for (int i = 0; i < n; i++)
                    if (hit < 0 && slot_used[i] && slot_key(i, kind) == key) hit = i;
                for (int i = 0; i < n; i++)
                    if (hit < 0 && !slot_used[i]) hit = i;
                if (hit < 0 && n >= SLOTS) begin
                    table_results.push_back(single_result(ST_FULL, 0));
                end else begin
                    if (hit < 0) begin
                        hit        = n;
                        live_count = n + 1;
                    end
                    slot_used[hit] = 1'b1;
                    slot_hl[hit]   = hl;
                    slot_obj[hit]  = kind ? '0 : key;
                    slot_drw[hit]  = kind ? key : '0;
                    table_results.push_back(single_result(ST_OK, hit));
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < n; i++) begin
                    if (slot_key(i, kind) == key) begin
                        slot_used[i] = 1'b0;
                        slot_obj[i]  = '0;
                        slot_drw[i]  = '0;
                    end
                end
                table_results.push_back(single_result(ST_OK, 0));
            end
            OP_CLEAR: begin
                live_count = 0;
                table_results.push_back(single_result(ST_OK, 0));
            end
            OP_UNHL: begin
                for (int i = 0; i < n; i++) slot_hl[i] = 1'b0;
                table_results.push_back(single_result(ST_OK, 0));
            end
            OP_EMIT: begin
                nv        = 0;
                ni        = 0;
                sv        = 0;
                si        = 0;
                k         = 0;
                have_held = 1'b0;
                held      = '0;
                for (int pass = 0; pass < 2; pass++) begin
                    if (pass == 1) begin
                        si = ni;
                        sv = nv;
                    end
                    for (int i = 0; i < n; i++) begin
                        if (!slot_used[i] || slot_hl[i] != (pass != 0)) continue;
                        if (nv + VTX_ROOM >= int'(vtx_cap) || ni + IDX_ROOM >= int'(idx_cap))
                            break;
                        if (k >= MAX_RESULTS) break;
                        // hold one back so the final one can carry the counts
                        if (have_held) table_results.push_back(held);
                        held                = '0;
                        held.status         = ST_OK;
                        held.slot           = 6'(i);
                        held.base_vertex    = 8'(nv);
                        held.base_index     = 9'(ni);
                        held.is_highlighted = (pass != 0);
                        have_held           = 1'b1;
                        k++;
                        nv += VTX_PER_SLOT;
                        ni += IDX_PER_SLOT;
                    end
                end
                if (!have_held) begin
                    table_results.push_back(single_result(ST_EMPTY, 0));
                end else begin
                    held.last           = 1'b1;
                    held.split_index    = 9'(si);
                    held.split_vertex   = 9'(sv);
                    held.total_indices  = 9'(ni);
                    held.total_vertices = 9'(nv);
                    table_results.push_back(held);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_obj[i]  = '0;
                slot_drw[i]  = '0;
                slot_hl[i]   = 1'b0;
            end
            live_count = 0;
            vtx_cap    = MAX_VTX_RST;
            idx_cap    = MAX_IDX_RST;
            bad_count  = 0;
            table_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_VTX: vtx_cap = i_cfg_data;
                    CFG_MAX_IDX: idx_cap = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got                = '0;
                got.status         = t_status'(i_m_tdata[1:0]);
                got.slot           = i_m_tdata[7:2];
                got.base_vertex    = i_m_tdata[15:8];
                got.base_index     = i_m_tdata[24:16];
                got.is_highlighted = i_m_tdata[25];
                got.last           = i_m_tlast;
                got.split_index    = i_m_tdata[34:26];
                got.split_vertex   = i_m_tdata[43:35];
                got.total_indices  = i_m_tdata[52:44];
                got.total_vertices = i_m_tdata[61:53];
                if (table_results.size() == 0) begin
                    if (bad_count < REPORT_MAX)
                        $display("%0t: result with none outstanding: %s", $realtime,
                                 res_text(got));
                    bad_count++;
                end else begin
                    want = table_results.pop_front();
                    if (got !== want || i_m_tdata[63:62] !== 2'b00) begin
                        if (bad_count < REPORT_MAX)
                            $display("%0t: result mismatch\n  exp %s\n  got %s pad=%b",
                                     $realtime, res_text(want), res_text(got),
                                     i_m_tdata[63:62]);
                        bad_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                run_table_op(i_s_tdata[2:0], i_s_tuser[0], i_s_tdata[34:3], i_s_tdata[35]);
        end
        o_bad_results <= bad_count;
        o_results_due <= table_results.size();
    end

endmodule

// ----- tb/sv/keyed_slot_table_draw_list_unit_tb.sv -----
// Testbench top for the keyed slot table draw-list unit: stimulus, clocking and verdict.
`timescale 1ns / 100ps
module keyed_slot_table_draw_list_unit_tb;
    import kstdl_pkg::*;

    // Opcodes outside the defined set; the block swallows them silently
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    localparam int IDLE_PCT       = 16;
    localparam int PHASES         = 10;
    localparam int CALM_PHASE     = 6;     // no idling on either side in this one
    localparam int FILL_LEN       = 80;    // enough adds to run the table full
    localparam int MIX_LEN        = 36;
    localparam int POOL_SIZE      = 80;
    // An emit over a full table walks 2 * 65 slots; allow for that plus margin
    localparam int SETTLE_CYCLES  = 160;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic [0:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        m_ready = 1'b0;
    logic [63:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [9:0]  i_cfg_data;

    int          bad_results;
    int          results_due;
    int          quiet_cycles = 0;
    bit          calm         = 1'b0;
    logic [31:0] key_pool [POOL_SIZE];

    keyed_slot_table_draw_list_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    keyed_slot_table_draw_list_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tlast     (o_m_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_bad_results (bad_results),
        .o_results_due (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random back-pressure at IDLE_PCT percent, none while calm
    always @(negedge i_clk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: any transaction on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && m_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one command and holds it until the transaction completes.
    // Random gaps go in front; tvalid stays high across back-to-back commands.
    task automatic issue_command(input logic [2:0] op, input logic kind,
                                 input logic [31:0] key, input logic hl);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, hl, key, op};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Stops sending, waits for every outstanding result, then lets any
    // silently dropped command work its way through the block.
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (results_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [9:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly ids from a shared pool so adds and removes hit each other
    function automatic logic [31:0] pick_key(int fresh_pct);
        if ($urandom_range(99) < fresh_pct) return $urandom;
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    initial begin
        int          counted;
        int          len;
        int          roll;
        logic        kind;
        logic        hl;
        logic [9:0]  vtx;
        logic [9:0]  idx;
        logic [2:0]  op;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- Directed part, reset register values ----
        issue_command(OP_EMIT,   1'b0, 32'h0, 1'b0);          // empty table: empty status
        issue_command(OP_REMOVE, 1'b0, 32'h0, 1'b0);          // remove on empty table
        issue_command(OP_ADD,    1'b0, 32'h0000_0000, 1'b0);  // the invalid id as a key
        issue_command(OP_ADD,    1'b1, 32'hFFFF_FFFF, 1'b1);
        issue_command(OP_ADD,    1'b0, 32'h0000_0005, 1'b1);
        issue_command(OP_ADD,    1'b0, 32'h0000_0005, 1'b0);  // matching id: update in place
        issue_command(OP_ADD,    1'b1, 32'h0000_0005, 1'b1);  // same id, other kind: new slot
        issue_command(OP_EMIT,   1'b0, 32'h0, 1'b0);          // both passes populated
        issue_command(OP_UNHL,   1'b0, 32'h0, 1'b0);
        issue_command(OP_EMIT,   1'b1, 32'h0, 1'b1);          // plain pass only
        // drawable id zero frees every slot added by object id
        issue_command(OP_REMOVE, 1'b1, 32'h0000_0000, 1'b0);
        issue_command(OP_ADD,    1'b1, 32'h0000_0007, 1'b1);  // reuses the first free slot
        issue_command(OP_FIRST_UNUSED,        1'b1, 32'hFFFF_FFFF, 1'b1);
        issue_command(OP_FIRST_UNUSED + 3'd1, 1'b0, 32'h0, 1'b0);
        issue_command(OP_LAST_UNUSED,         1'b1, 32'h0, 1'b1);
        issue_command(OP_EMIT,   1'b0, 32'h0, 1'b0);
        issue_command(OP_CLEAR,  1'b0, 32'h0, 1'b0);          // hides slots, keeps contents
        issue_command(OP_EMIT,   1'b0, 32'h0, 1'b0);          // nothing live any more
        issue_command(OP_ADD,    1'b1, 32'hFFFF_FFFF, 1'b0);  // appends at slot 0 again
        issue_command(OP_EMIT,   1'b0, 32'h0, 1'b0);
        settle();

        // ---- Random phases, each under its own register setting ----
        for (int p = 0; p < PHASES; p++) begin
            calm = (p == CALM_PHASE);
            case (p % 5)
                0: begin vtx = 10'd512; idx = 10'd768; end   // widest headroom
                1: begin vtx = 10'd0;   idx = 10'd0;   end   // no headroom at all
                2: begin
                    vtx = 10'($urandom_range(512));
                    idx = 10'($urandom_range(768));
                end
                3: begin vtx = MAX_VTX_RST; idx = MAX_IDX_RST; end
                default: begin
                    // one limit tight, the other wide
                    vtx = (p < 5) ? 10'($urandom_range(60, 6)) : 10'd512;
                    idx = (p < 5) ? 10'd768 : 10'($urandom_range(90, 12));
                end
            endcase
            write_reg(CFG_MAX_VTX, vtx);
            write_reg(CFG_MAX_IDX, idx);

            len     = (p % 5 == 0) ? FILL_LEN : MIX_LEN;
            counted = 0;
            while (counted < len) begin
                roll = $urandom_range(99);
                kind = 1'($urandom_range(1));
                hl   = 1'($urandom_range(1));
                if (p % 5 == 0) begin
                    // fill phase: mostly fresh adds so the table runs full
                    if (roll < 85)      issue_command(OP_ADD, kind, pick_key(75), hl);
                    else if (roll < 93) issue_command(OP_EMIT, kind, $urandom, hl);
                    else if (roll < 97) issue_command(OP_REMOVE, kind, pick_key(10), hl);
                    else                issue_command(OP_UNHL, kind, $urandom, hl);
                    counted++;
                end else begin
                    if (roll < 40)      op = OP_ADD;
                    else if (roll < 58) op = OP_REMOVE;
                    else if (roll < 80) op = OP_EMIT;
                    else if (roll < 86) op = OP_UNHL;
                    else if (roll < 90) op = OP_CLEAR;
                    else                op = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
                    issue_command(op, kind, pick_key(15), hl);
                    if (op < OP_FIRST_UNUSED) counted++;
                end
                // now and then let the pipeline drain mid-phase
                if ($urandom_range(99) < 2) settle();
            end
            settle();
        end

        if (bad_results == 0 && results_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
